@@ hdl/brfifo_pkg.sv @@
// Package for the byte ring FIFO: command and status codes, beat structs
// and the internal request/metadata structs. No dependencies.
package brfifo_pkg;

   localparam int SIZE_W  = 9;    // ring size register width
   localparam int PTR_W   = 8;    // read and write pointer width
   localparam int BYTE_W  = 8;
   localparam int DROP_W  = 16;
   localparam logic [DROP_W-1:0] DROP_MAX = '1;
   localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_PEEK  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [BYTE_W-1:0] data_in;
      logic [BYTE_W-1:0] peek_offset;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_out;
      status_type        status;
      logic [PTR_W-1:0]  fill_count;
      logic [SIZE_W-1:0] space_count;
      logic [DROP_W-1:0] overflow_total;
   } rsp_type;

   // one memory access per item: a write for push, a read for pop or peek
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [PTR_W-1:0]  ptr;
      logic [BYTE_W-1:0] wdata;
   } ram_req_type;

   // everything of a result but the byte that comes back from the memory
   typedef struct packed {
      logic              use_rdata;
      status_type        status;
      logic [PTR_W-1:0]  fill;
      logic [SIZE_W-1:0] space;
      logic [DROP_W-1:0] overflow;
   } meta_type;

endpackage

@@ hdl/byte_ring_fifo_with_peek.sv @@
// Byte ring FIFO with peek: one item in, one result beat out. An accepted item
// passes the store read of stage one, then the output register. Takes one item
// per cycle unless req_stall is high: each item makes at most one access to the
// single-port store, and the output register lets a new item in while a
// result waits. Synchronous reset empties the ring, zeroes the overflow
// total and sets the size to its largest value; store contents stay undefined.
module byte_ring_fifo_with_peek #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  brfifo_pkg::req_type           req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output brfifo_pkg::rsp_type           rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [brfifo_pkg::SIZE_W-1:0] csr_data
);
   import brfifo_pkg::*;

   localparam int SIZE_CAP = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;
   localparam int ADDR_W   = $clog2(SIZE_CAP);

   ram_req_type       ram_req;
   meta_type          meta;
   logic [BYTE_W-1:0] ram_rdata;

   logic     req_accept, out_free, s1_move;
   logic     s1_valid_ff, s1_valid_in;
   meta_type s1_meta_ff;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_ff;

   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   brfifo_ctrl #(
      .SIZE_CAP (SIZE_CAP)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .item     (req_payload),
      .cfg_we   (csr_valid),
      .cfg_data (csr_data),
      .ram_req  (ram_req),
      .meta     (meta)
   );

   brfifo_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SIZE_CAP)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.wr_en),
      .re    (ram_req.rd_en),
      .addr  (ram_req.ptr[ADDR_W-1:0]),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

   // read data holds while stage one is stalled: no new read is issued then
   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_meta_ff <= meta;
      end
      if (s1_move) begin
         out_ff.data_out       <= s1_meta_ff.use_rdata ? ram_rdata : '0;
         out_ff.status         <= s1_meta_ff.status;
         out_ff.fill_count     <= s1_meta_ff.fill;
         out_ff.space_count    <= s1_meta_ff.space;
         out_ff.overflow_total <= s1_meta_ff.overflow;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

@@ hdl/brfifo_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module brfifo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/brfifo_ctrl.sv @@
// Pointer, size and overflow control of the byte ring FIFO: decodes each
// accepted command, drives the store access and the result metadata. Uses brfifo_pkg.
module brfifo_ctrl #(
   parameter int SIZE_CAP = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  brfifo_pkg::req_type          item,
   input  logic                         cfg_we,
   input  logic [brfifo_pkg::SIZE_W-1:0] cfg_data,
   output brfifo_pkg::ram_req_type      ram_req,
   output brfifo_pkg::meta_type         meta
);
   import brfifo_pkg::*;

   localparam logic [SIZE_W-1:0] SIZE_TOP = SIZE_W'(SIZE_CAP);

   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [DROP_W-1:0] drop_ff, drop_in;

   logic [SIZE_W-1:0] fill, fill_after;
   logic [SIZE_W-1:0] wp_inc, rp_inc, peek_sum, peek_idx;
   logic [PTR_W-1:0]  wp_adv, rp_adv;
   logic              full;

   always_comb begin
      // clamp the written size into the usable range
      if (cfg_data < SIZE_MIN) begin
         size_in = SIZE_MIN;
      end else if (cfg_data > SIZE_TOP) begin
         size_in = SIZE_TOP;
      end else begin
         size_in = cfg_data;
      end
   end

   always_comb begin
      if (rp_ff <= wp_ff) begin
         fill = {1'b0, wp_ff} - {1'b0, rp_ff};
      end else begin
         fill = {1'b0, wp_ff} + size_ff - {1'b0, rp_ff};
      end

      wp_inc = {1'b0, wp_ff} + SIZE_W'(1);
      rp_inc = {1'b0, rp_ff} + SIZE_W'(1);
      wp_adv = (wp_inc >= size_ff) ? '0 : wp_inc[PTR_W-1:0];
      rp_adv = (rp_inc >= size_ff) ? '0 : rp_inc[PTR_W-1:0];
      full   = (wp_adv == rp_ff);

      // wrap the peek slot around the ring
      peek_sum = {1'b0, rp_ff} + {1'b0, item.peek_offset};
      peek_idx = (peek_sum >= size_ff) ? peek_sum - size_ff : peek_sum;

      rp_in         = rp_ff;
      wp_in         = wp_ff;
      drop_in       = drop_ff;
      fill_after    = fill;
      ram_req       = '0;
      ram_req.wdata = item.data_in;
      meta.use_rdata = 1'b0;
      meta.status    = ST_OK;

      unique case (item.cmd)
         CMD_PUSH: begin
            if (full) begin
               meta.status = ST_FULL;
               if (drop_ff != DROP_MAX) begin
                  drop_in = drop_ff + DROP_W'(1);
               end
            end else begin
               ram_req.wr_en = 1'b1;
               ram_req.ptr   = wp_ff;
               wp_in         = wp_adv;
               fill_after    = fill + SIZE_W'(1);
            end
         end
         CMD_POP: begin
            if (fill == '0) begin
               meta.status = ST_EMPTY;
            end else begin
               ram_req.rd_en  = 1'b1;
               ram_req.ptr    = rp_ff;
               meta.use_rdata = 1'b1;
               rp_in          = rp_adv;
               fill_after     = fill - SIZE_W'(1);
            end
         end
         CMD_PEEK: begin
            if (fill == '0) begin
               meta.status = ST_EMPTY;
            end else if ({1'b0, item.peek_offset} >= fill) begin
               meta.status = ST_RANGE;
            end else begin
               ram_req.rd_en  = 1'b1;
               ram_req.ptr    = peek_idx[PTR_W-1:0];
               meta.use_rdata = 1'b1;
            end
         end
         CMD_CLEAR: begin
            rp_in      = '0;
            wp_in      = '0;
            drop_in    = '0;
            fill_after = '0;
         end
      endcase

      // no store access unless an item is really taken
      ram_req.wr_en = ram_req.wr_en & accept;
      ram_req.rd_en = ram_req.rd_en & accept;

      meta.fill     = fill_after[PTR_W-1:0];
      meta.space    = size_ff - fill_after;
      meta.overflow = drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff   <= '0;
         wp_ff   <= '0;
         size_ff <= SIZE_TOP;
         drop_ff <= '0;
      end else if (cfg_we) begin
         // new size empties the ring, overflow total is kept
         rp_ff   <= '0;
         wp_ff   <= '0;
         size_ff <= size_in;
      end else if (accept) begin
         rp_ff   <= rp_in;
         wp_ff   <= wp_in;
         drop_ff <= drop_in;
      end
   end

endmodule

@@ hdl/brfifo_checker.sv @@
// Port-level checks for the byte ring FIFO, bound to the top level.
// Uses brfifo_pkg.
module brfifo_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input brfifo_pkg::req_type           req_payload,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input brfifo_pkg::rsp_type           rsp_payload,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [brfifo_pkg::SIZE_W-1:0] csr_data
);
   import brfifo_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // at least one slot stays free, and the ring never exceeds its largest size
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.space_count != '0 &&
         ({1'b0, rsp_payload.space_count} + 10'(rsp_payload.fill_count)) <= 10'd256)
      else $error("fill and space counts inconsistent");

   // refused commands return no byte
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.data_out == '0)
      else $error("refused command returned data");

   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_EMPTY |-> rsp_payload.fill_count == '0)
      else $error("empty status with nonzero fill");

   a_full_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_FULL |-> rsp_payload.overflow_total != '0)
      else $error("dropped push not counted");

endmodule

bind byte_ring_fifo_with_peek brfifo_checker u_brfifo_checker (.*);
